// ----- hdl/rlbc_pkg.sv -----
// Shared types and constants for the run-length byte compressor.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rlbc_pkg;

    localparam int SYM_W   = 8;
    localparam int RUN_W   = 16;
    localparam int CNT_W   = 21;
    localparam int DIG_W   = 4;
    localparam int NUM_DIG = 5;
    localparam int NDIG_W  = 3;

    // Longest run kept before it is split, and saturation point of the count
    localparam logic [RUN_W-1:0] RUN_CAP = 16'd65535;
    localparam logic [CNT_W-1:0] LEN_CAP = 21'd1048576;

    // floor(v / 10) == (v * RECIP10) >> RECIP_SH for every 16-bit v
    localparam logic [RUN_W-1:0] RECIP10  = 16'd52429;
    localparam int               RECIP_SH = 19;
    localparam logic [SYM_W-1:0] ASCII_0  = 8'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SYM,
        ST_CONV,
        ST_DIG
    } state_t;

    typedef struct packed {
        logic accept;        // take the input word into the run state
        logic load_sym;      // put the flushed run symbol in the output register
        logic conv_step;     // produce one decimal digit of the run length
        logic load_dig;      // put the leading digit in the output register
        logic start_second;  // flush the run opened by the final byte
        logic end_stream;    // clear the compressed count
        logic mark_last;     // flag the word loaded now as the last one
    } cmd_t;

    typedef struct packed {
        logic flush_now;     // accepted word closes a run
        logic multi;         // flushed run is longer than one
        logic conv_done;     // remaining value has no more digits
        logic dig_one;       // one digit left to send
        logic second;        // final byte opened a run that still needs flushing
        logic final_word;    // the word being flushed ended the stream
    } status_t;

endpackage

// ----- hdl/rlbc_datapath.sv -----
// Datapath of the run-length byte compressor: run state, digit conversion,
// output register and compressed count. Depends on rlbc_pkg.
`timescale 1ns / 1ps

module rlbc_datapath
    import rlbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SYM_W-1:0] in_byte,
    input  logic             in_last,
    input  cmd_t             cmd,
    output status_t          st,
    output logic [SYM_W-1:0] out_byte,
    output logic             out_last,
    output logic [CNT_W-1:0] out_length
);

    logic [SYM_W-1:0]  sym_reg;
    logic [RUN_W-1:0]  len_reg;
    logic [SYM_W-1:0]  flush_sym_reg;
    logic [RUN_W-1:0]  flush_len_reg;
    logic              second_reg;
    logic              final_reg;
    logic [RUN_W-1:0]  v_reg;
    logic [DIG_W-1:0]  dig_reg [NUM_DIG];
    logic [NDIG_W-1:0] ndig_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SYM_W-1:0]  obyte_reg;
    logic [CNT_W-1:0]  olen_reg;
    logic              olast_reg;

    logic                   run_open;
    logic                   same;
    logic [RUN_W-1:0]       len_inc;
    logic [2*RUN_W-1:0]     prod;
    logic [RUN_W-1:0]       q;
    logic [RUN_W-1:0]       rem;
    logic [CNT_W-1:0]       count_inc;

    always_comb
    begin
        run_open  = (len_reg != '0);
        same      = run_open && (in_byte == sym_reg) && (len_reg < RUN_CAP);
        len_inc   = len_reg + 1'b1;
        prod      = v_reg * RECIP10;
        q         = RUN_W'(prod >> RECIP_SH);
        rem       = v_reg - ((q << 3) + (q << 1));
        count_inc = (count_reg < LEN_CAP) ? count_reg + 1'b1 : count_reg;
    end

    always_comb
    begin
        st.flush_now  = in_last || (run_open && !same);
        st.multi      = (flush_len_reg > RUN_W'(1));
        st.conv_done  = (q == '0);
        st.dig_one    = (ndig_reg == NDIG_W'(1));
        st.second     = second_reg;
        st.final_word = final_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            second_reg <= 1'b0;
            final_reg  <= 1'b0;
            ndig_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                second_reg <= run_open && !same && in_last;
                final_reg  <= in_last;
                if (same)
                    len_reg <= in_last ? '0 : len_inc;
                else if (run_open)
                    len_reg <= RUN_W'(1);
                else
                    len_reg <= in_last ? '0 : RUN_W'(1);
            end
            if (cmd.start_second)
            begin
                len_reg    <= '0;
                second_reg <= 1'b0;
            end
            if (cmd.load_sym)
                ndig_reg <= '0;
            if (cmd.conv_step)
                ndig_reg <= ndig_reg + 1'b1;
            if (cmd.load_dig)
                ndig_reg <= ndig_reg - 1'b1;
            if (cmd.end_stream)
                count_reg <= '0;
            else if (cmd.load_sym || cmd.load_dig)
                count_reg <= count_inc;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (same)
            begin
                flush_sym_reg <= sym_reg;
                flush_len_reg <= len_inc;
            end
            else if (run_open)
            begin
                flush_sym_reg <= sym_reg;
                flush_len_reg <= len_reg;
                sym_reg       <= in_byte;
            end
            else
            begin
                flush_sym_reg <= in_byte;
                flush_len_reg <= RUN_W'(1);
                sym_reg       <= in_byte;
            end
        end
        if (cmd.start_second)
        begin
            flush_sym_reg <= sym_reg;
            flush_len_reg <= len_reg;
        end
        if (cmd.load_sym)
        begin
            obyte_reg <= flush_sym_reg;
            olen_reg  <= count_inc;
            olast_reg <= cmd.mark_last;
            v_reg     <= flush_len_reg;
        end
        // Digits come out least significant first; shift them in at the head
        // so the most significant one ends up at the front.
        if (cmd.conv_step)
        begin
            v_reg      <= q;
            dig_reg[0] <= rem[DIG_W-1:0];
            for (int i = 1; i < NUM_DIG; i++)
                dig_reg[i] <= dig_reg[i-1];
        end
        if (cmd.load_dig)
        begin
            obyte_reg <= ASCII_0 + SYM_W'(dig_reg[0]);
            olen_reg  <= count_inc;
            olast_reg <= cmd.mark_last;
            for (int i = 0; i < NUM_DIG - 1; i++)
                dig_reg[i] <= dig_reg[i+1];
        end
    end

    assign out_byte   = obyte_reg;
    assign out_last   = olast_reg;
    assign out_length = olen_reg;

endmodule

// ----- hdl/rlbc_ctrl.sv -----
// Controller of the run-length byte compressor: sequences accept, symbol,
// digit conversion and digit output. Depends on rlbc_pkg.
`timescale 1ns / 1ps

module rlbc_ctrl
    import rlbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot;
    logic   finish;

    assign slot = !out_valid_reg || out_ready;

    // A flush ends once its last word is loaded
    always_comb
    begin
        unique case (state_reg)
            ST_SYM:  finish = slot && !st.multi;
            ST_DIG:  finish = slot && st.dig_one;
            default: finish = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && st.flush_now)
                    state_next = ST_SYM;
            end
            ST_SYM:
            begin
                if (slot)
                begin
                    if (st.multi)
                        state_next = ST_CONV;
                    else if (st.second)
                        state_next = ST_SYM;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                if (st.conv_done)
                    state_next = ST_DIG;
            end
            ST_DIG:
            begin
                if (finish)
                    state_next = st.second ? ST_SYM : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SYM:  cmd.load_sym  = slot;
            ST_CONV: cmd.conv_step = 1'b1;
            ST_DIG:  cmd.load_dig  = slot;
            default: cmd = '0;
        endcase
        cmd.start_second = finish && st.second;
        cmd.end_stream   = finish && !st.second && st.final_word;
        cmd.mark_last    = finish && !st.second && st.final_word;
    end

    always_comb
    begin
        if (cmd.load_sym || cmd.load_dig)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/run_length_byte_compressor.sv -----
// Run-length byte compressor with decimal run counts, top level.
// Output: a word that continues a run gives no output; a closing word is accepted,
//   then its symbol word is loaded and, for a run longer than one, its length digits
//   (up to 5) are converted one per cycle and then loaded as one word each.
// Throughput: 1 word per cycle inside a run; a flush holds off input until its last word loads.
// Reset: asynchronous, active low; clears the open run and the output count.
`timescale 1ns / 1ps

module run_length_byte_compressor
    import rlbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [28:8] out_length, zero above
    output logic        m_axis_tlast    // out_last
);

    cmd_t             cmd;
    status_t          st;
    logic [SYM_W-1:0] out_byte;
    logic [CNT_W-1:0] out_length;

    rlbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    rlbc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .cmd        (cmd),
        .st         (st),
        .out_byte   (out_byte),
        .out_last   (m_axis_tlast),
        .out_length (out_length)
    );

    assign m_axis_tdata = {3'b000, out_length, out_byte};

    // A final word always flushes, so input must stall right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input not stalled after final word");

    // Every output word counts itself
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:8] != 21'd0))
        else $error("output word with zero compressed length");

    // Only one of accept, symbol load, digit load and conversion runs at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load_sym, cmd.conv_step, cmd.load_dig}))
        else $error("conflicting datapath commands");

endmodule
